[rtl/dual_quadrature_speed_meter_assert.svh]
// Assertion macros shared by the speed meter RTL.
`ifndef DUAL_QUADRATURE_SPEED_METER_ASSERT_SVH
`define DUAL_QUADRATURE_SPEED_METER_ASSERT_SVH
`ifndef SYNTH
`define DQSM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dqsm: check failed");
`define DQSM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("dqsm: forbidden condition");
`else
`define DQSM_ASSERT(lbl, clk, rst_n, prop)
`define DQSM_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[rtl/dqsm_pkg.sv]
`default_nettype none
package dqsm_pkg;

    localparam int COUNT_WIDTH_DEF = 32;

    localparam int CIRC_W = 24;
    localparam int PPR_W  = 16;
    localparam int SPM_W  = 10;
    localparam int DIV_W  = PPR_W + SPM_W;
    localparam int CFG_W  = CIRC_W;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_CIRC = 2'd0;
    localparam logic [IDX_W-1:0] REG_PPR  = 2'd1;
    localparam logic [IDX_W-1:0] REG_SPM  = 2'd2;

    localparam logic [CIRC_W-1:0] CIRC_RST = 24'd204204;
    localparam logic [PPR_W-1:0]  PPR_RST  = 16'd1040;
    localparam logic [SPM_W-1:0]  SPM_RST  = 10'd10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_MUL,
        S_DSET,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic take;
        logic setup;
        logic mul_step;
        logic div_setup;
        logic div_step;
        logic finish;
        logic load_item;
        logic load_done;
        logic wheel;
    } t_dp_cmd;

    typedef struct packed {
        logic step_last;
    } t_dp_stat;

    // Net x4 count change of one wheel: -2 .. +2
    function automatic logic signed [2:0] quad_step(input logic a, input logic b,
                                                    input logic pa, input logic pb);
        logic signed [2:0] s;
        s = 3'sd0;
        if (a != pa) begin
            s = b ? s + 3'sd1 : s - 3'sd1;
        end
        if (b != pb) begin
            s = a ? s - 3'sd1 : s + 3'sd1;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

[rtl/dqsm_datapath.sv]
`default_nettype none
`include "dual_quadrature_speed_meter_assert.svh"
module dqsm_datapath import dqsm_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [IDX_W-1:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0]       i_cfg_wr_data,
    input  wire logic [3:0]             i_levels,
    input  wire logic                   i_sample_tick,
    input  wire logic                   i_clear,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_stat                    o_stat,
    output logic [COUNT_WIDTH-1:0]      o_out_count0,
    output logic [COUNT_WIDTH-1:0]      o_out_count1,
    output logic [31:0]                 o_out_speed0,
    output logic [31:0]                 o_out_speed1
);

    localparam int PW     = COUNT_WIDTH + CIRC_W;
    localparam int STEP_W = $clog2(PW);
    localparam int HW     = COUNT_WIDTH + DIV_W + 32;

    logic [CIRC_W-1:0]      r_circ;
    logic [PPR_W-1:0]       r_ppr;
    logic [SPM_W-1:0]       r_spm;
    logic [DIV_W-1:0]       r_div;
    logic [3:0]             r_prev;
    logic [COUNT_WIDTH-1:0] r_count     [2];
    logic [COUNT_WIDTH-1:0] r_last      [2];
    logic [31:0]            r_speed     [2];
    logic [COUNT_WIDTH-1:0] r_mag       [2];
    logic                   r_neg       [2];
    logic [CIRC_W-1:0]      r_mplier;
    logic [PW-1:0]          r_acc;
    logic [DIV_W-1:0]       r_rem;
    logic [STEP_W-1:0]      r_step;
    logic [COUNT_WIDTH-1:0] r_out_count [2];
    logic [31:0]            r_out_speed [2];

    logic [COUNT_WIDTH-1:0] n_count     [2];
    logic [COUNT_WIDTH-1:0] w_delta     [2];
    logic [COUNT_WIDTH-1:0] w_dmag      [2];
    logic [COUNT_WIDTH-1:0] w_mag_sel;
    logic                   w_neg_sel;
    logic [DIV_W:0]         w_rem_sh;
    logic                   w_rem_ge;
    logic [31:0]            w_lim;
    logic                   w_q_over;
    logic                   w_hi_over;
    logic [31:0]            w_q32;
    logic [31:0]            w_speed;

    always_comb begin
        n_count[0] = r_count[0] + COUNT_WIDTH'(quad_step(i_levels[0], i_levels[1],
                                                         r_prev[0], r_prev[1]));
        n_count[1] = r_count[1] + COUNT_WIDTH'(quad_step(i_levels[2], i_levels[3],
                                                         r_prev[2], r_prev[3]));
        for (int w = 0; w < 2; w++) begin
            w_delta[w] = n_count[w] - r_last[w];
            w_dmag[w]  = w_delta[w][COUNT_WIDTH-1] ? (~w_delta[w] + 1'b1) : w_delta[w];
        end
    end

    assign w_mag_sel = r_mag[i_cmd.wheel];
    assign w_neg_sel = r_neg[i_cmd.wheel];

    // Restoring division: one quotient bit per step
    assign w_rem_sh = {r_rem, r_acc[PW-1]};
    assign w_rem_ge = (w_rem_sh >= {1'b0, r_div});

    always_comb begin
        w_lim     = w_neg_sel ? 32'h8000_0000 : 32'h7FFF_FFFF;
        w_q_over  = (|r_acc[PW-1:32]) || (r_acc[31:0] > w_lim);
        // Integer part of mag / div beyond 32 bits saturates even when circumference is zero
        w_hi_over = (HW'(w_mag_sel) >= HW'({r_div, 32'h0000_0000}));
        w_q32     = (w_q_over || w_hi_over) ? w_lim : r_acc[31:0];
        if (r_div == '0) begin
            w_speed = '0;
        end else begin
            w_speed = w_neg_sel ? (~w_q32 + 1'b1) : w_q32;
        end
    end

    assign o_stat.step_last = (r_step == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_circ <= CIRC_RST;
            r_ppr  <= PPR_RST;
            r_spm  <= SPM_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_CIRC: r_circ <= i_cfg_wr_data[CIRC_W-1:0];
                REG_PPR:  r_ppr  <= i_cfg_wr_data[PPR_W-1:0];
                REG_SPM:  r_spm  <= i_cfg_wr_data[SPM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_div <= DIV_W'(r_ppr * r_spm);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            for (int w = 0; w < 2; w++) begin
                r_count[w] <= '0;
                r_last[w]  <= '0;
                r_speed[w] <= '0;
            end
        end else begin
            if (i_cmd.take) begin
                r_prev <= i_levels;
                if (i_clear) begin
                    for (int w = 0; w < 2; w++) begin
                        r_count[w] <= '0;
                        r_last[w]  <= '0;
                        r_speed[w] <= '0;
                    end
                end else begin
                    for (int w = 0; w < 2; w++) begin
                        r_count[w] <= n_count[w];
                        if (i_sample_tick) begin
                            r_last[w] <= n_count[w];
                        end
                    end
                end
            end
            if (i_cmd.finish) begin
                r_speed[i_cmd.wheel] <= w_speed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            for (int w = 0; w < 2; w++) begin
                r_mag[w] <= w_dmag[w];
                r_neg[w] <= w_delta[w][COUNT_WIDTH-1];
            end
        end
        if (i_cmd.setup) begin
            r_acc    <= '0;
            r_mplier <= r_circ;
            r_step   <= STEP_W'(CIRC_W - 1);
        end else if (i_cmd.mul_step) begin
            // MSB-first shift-add of magnitude times circumference
            r_acc    <= (r_acc << 1) + (r_mplier[CIRC_W-1] ? PW'(w_mag_sel) : '0);
            r_mplier <= r_mplier << 1;
            r_step   <= r_step - 1'b1;
        end else if (i_cmd.div_setup) begin
            r_rem  <= '0;
            r_step <= STEP_W'(PW - 1);
        end else if (i_cmd.div_step) begin
            r_rem  <= w_rem_ge ? DIV_W'(w_rem_sh - {1'b0, r_div}) : w_rem_sh[DIV_W-1:0];
            r_acc  <= {r_acc[PW-2:0], w_rem_ge};
            r_step <= r_step - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            for (int w = 0; w < 2; w++) begin
                r_out_count[w] <= i_clear ? '0 : n_count[w];
                r_out_speed[w] <= i_clear ? '0 : r_speed[w];
            end
        end else if (i_cmd.load_done) begin
            for (int w = 0; w < 2; w++) begin
                r_out_count[w] <= r_count[w];
                r_out_speed[w] <= r_speed[w];
            end
        end
    end

    assign o_out_count0 = r_out_count[0];
    assign o_out_count1 = r_out_count[1];
    assign o_out_speed0 = r_out_speed[0];
    assign o_out_speed1 = r_out_speed[1];

    `DQSM_ASSERT(a_count_hold, i_clk, i_rst_n, !i_cmd.take |=> $stable(r_count[0]) && $stable(r_count[1]))
    `DQSM_ASSERT(a_zero_div_speed, i_clk, i_rst_n, (i_cmd.finish && (r_div == '0)) |=> (r_speed[$past(i_cmd.wheel)] == '0))
    `DQSM_ASSERT_NEVER(a_take_not_finish, i_clk, i_rst_n, i_cmd.take && i_cmd.finish)

endmodule
`default_nettype wire

[rtl/dqsm_ctrl.sv]
`default_nettype none
`include "dual_quadrature_speed_meter_assert.svh"
module dqsm_ctrl import dqsm_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_need_speed,
    input  wire logic     i_out_stall,
    input  wire t_dp_stat i_stat,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output t_dp_cmd       o_cmd
);

    t_state r_state, n_state;
    logic   r_wheel, n_wheel;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wheel     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wheel     <= n_wheel;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_wheel     = r_wheel;
        n_out_valid = r_out_valid && i_out_stall;
        o_in_stall  = 1'b1;
        o_cmd       = '0;
        o_cmd.wheel = r_wheel;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = !w_out_free;
                if (i_in_valid && w_out_free) begin
                    o_cmd.take = 1'b1;
                    if (i_need_speed) begin
                        n_state = S_SETUP;
                        n_wheel = 1'b0;
                    end else begin
                        o_cmd.load_item = 1'b1;
                        n_out_valid     = 1'b1;
                    end
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_stat.step_last) begin
                    n_state = S_DSET;
                end
            end
            S_DSET: begin
                o_cmd.div_setup = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.step_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                if (r_wheel) begin
                    n_state = S_OUT;
                end else begin
                    n_wheel = 1'b1;
                    n_state = S_SETUP;
                end
            end
            S_OUT: begin
                // hold the result until the output register frees up
                if (w_out_free) begin
                    o_cmd.load_done = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `DQSM_ASSERT(a_out_after_both, i_clk, i_rst_n, (r_state == S_OUT) |-> r_wheel)
    `DQSM_ASSERT(a_valid_from_load, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(o_cmd.load_item || o_cmd.load_done))
    `DQSM_ASSERT_NEVER(a_no_take_when_full, i_clk, i_rst_n, o_cmd.take && r_out_valid && i_out_stall)

endmodule
`default_nettype wire

[rtl/dual_quadrature_speed_meter.sv]
// Channel  | Handshake                  | Payload
// request  | i_in_valid / o_in_stall    | i_wheel{0,1}_{a,b}_level, i_sample_tick, i_clear
// result   | o_out_valid / i_out_stall  | o_wheel{0,1}_count, o_wheel{0,1}_speed
// config   | i_cfg_wr_en                | i_cfg_index, i_cfg_wr_data
//
// A request without a sample tick (or with clear) is handled in S_IDLE; a new one can follow next
// cycle unless the result is stalled. A tick request holds the input while both wheels go in turn
// through one shift-add multiplier (24 steps) and one restoring divider (COUNT_WIDTH+24 steps).
// The result register frees up when taken; a full, stalled result register stalls the input.
// Reset (i_rst_n low, synchronous) zeroes counts and speeds and reloads the config defaults.
`default_nettype none
module dual_quadrature_speed_meter import dqsm_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_wr_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_wheel0_a_level,
    input  wire logic               i_wheel0_b_level,
    input  wire logic               i_wheel1_a_level,
    input  wire logic               i_wheel1_b_level,
    input  wire logic               i_sample_tick,
    input  wire logic               i_clear,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_wheel0_count,
    output logic signed [31:0]      o_wheel1_count,
    output logic signed [31:0]      o_wheel0_speed,
    output logic signed [31:0]      o_wheel1_speed
);

    t_dp_cmd                w_cmd;
    t_dp_stat               w_stat;
    logic [COUNT_WIDTH-1:0] w_count0;
    logic [COUNT_WIDTH-1:0] w_count1;
    logic [31:0]            w_speed0;
    logic [31:0]            w_speed1;

    dqsm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_need_speed (i_sample_tick && !i_clear),
        .i_out_stall  (i_out_stall),
        .i_stat       (w_stat),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_cmd        (w_cmd)
    );

    dqsm_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_levels      ({i_wheel1_b_level, i_wheel1_a_level,
                         i_wheel0_b_level, i_wheel0_a_level}),
        .i_sample_tick (i_sample_tick),
        .i_clear       (i_clear),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_out_count0  (w_count0),
        .o_out_count1  (w_count1),
        .o_out_speed0  (w_speed0),
        .o_out_speed1  (w_speed1)
    );

    // sign-extend or truncate the count to the 32-bit port
    assign o_wheel0_count = 32'($signed(w_count0));
    assign o_wheel1_count = 32'($signed(w_count1));
    assign o_wheel0_speed = $signed(w_speed0);
    assign o_wheel1_speed = $signed(w_speed1);

endmodule
`default_nettype wire

[verif/tb_dual_quadrature_speed_meter.sv]
`timescale 1ns / 100ps
module tb_dual_quadrature_speed_meter;
    import dqsm_pkg::*;

    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 2 * COUNT_WIDTH_DEF + 120;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_SPACING  = 700;

    typedef struct packed {
        logic w0_a;
        logic w0_b;
        logic w1_a;
        logic w1_b;
        logic tick;
        logic clr;
    } t_pin_sample;

    typedef struct packed {
        logic [31:0] count0;
        logic [31:0] count1;
        logic [31:0] speed0;
        logic [31:0] speed1;
    } t_reading;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_W-1:0]   i_cfg_wr_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_wheel0_a_level = 1'b0;
    logic               i_wheel0_b_level = 1'b0;
    logic               i_wheel1_a_level = 1'b0;
    logic               i_wheel1_b_level = 1'b0;
    logic               i_sample_tick = 1'b0;
    logic               i_clear = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_wheel0_count;
    logic signed [31:0] o_wheel1_count;
    logic signed [31:0] o_wheel0_speed;
    logic signed [31:0] o_wheel1_speed;

    dual_quadrature_speed_meter i_dut (
        .i_clk,
        .i_rst_n,
        .i_cfg_wr_en,
        .i_cfg_index,
        .i_cfg_wr_data,
        .i_in_valid,
        .o_in_stall,
        .i_wheel0_a_level,
        .i_wheel0_b_level,
        .i_wheel1_a_level,
        .i_wheel1_b_level,
        .i_sample_tick,
        .i_clear,
        .o_out_valid,
        .i_out_stall,
        .o_wheel0_count,
        .o_wheel1_count,
        .o_wheel0_speed,
        .o_wheel1_speed
    );

    // Stimulus side
    t_pin_sample pin_samples_q[$];
    logic [1:0]  gen_w0 = 2'b00;    // {a, b} of the last queued sample
    logic [1:0]  gen_w1 = 2'b00;
    int          samples_sent = 0;
    logic        sample_taken = 1'b0;
    t_pin_sample next_sample;
    int          burst_left = 0;
    int          gap_left = 0;

    // Receiver side
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left = 0;
    int          hold_left = 0;
    int          next_hold_at = 60;

    // Predicted meter state
    logic [CIRC_W-1:0] circ_cfg;
    logic [PPR_W-1:0]  ppr_cfg;
    logic [SPM_W-1:0]  spm_cfg;
    logic [3:0]        last_pins;
    logic [31:0]       edge_cnt [2];
    logic [31:0]       tick_cnt [2];
    logic [31:0]       speed [2];
    t_reading          readings_q[$];
    int                readings_checked = 0;
    int                mismatches = 0;
    string             field_name [4] = '{"wheel1 speed", "wheel0 speed",
                                          "wheel1 count", "wheel0 count"};

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] count_edges(input logic [31:0] c, input logic a,
                                                input logic b, input logic pa,
                                                input logic pb);
        logic [31:0] n;
        n = c;
        if (a != pa) begin
            n = b ? n + 32'd1 : n - 32'd1;
        end
        if (b != pb) begin
            n = a ? n - 32'd1 : n + 32'd1;
        end
        return n;
    endfunction

    // Scale the delta by circumference over (ppr * period); truncate, then saturate.
    function automatic logic [31:0] wheel_speed(input logic [31:0] delta);
        logic              neg;
        logic [31:0]       mag32;
        longint unsigned   mag, dv, circ, hi, lo, q, lim;
        neg   = delta[31];
        mag32 = neg ? (~delta + 32'd1) : delta;
        mag   = 64'(mag32);
        circ  = 64'(circ_cfg);
        dv    = 64'(ppr_cfg);
        dv    = dv * 64'(spm_cfg);
        if (dv == 0) begin
            return 32'd0;
        end
        hi  = mag / dv;
        lo  = mag % dv;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        q   = hi * circ + (lo * circ) / dv;
        if (q > lim) begin
            q = lim;
        end
        return neg ? (~q[31:0] + 32'd1) : q[31:0];
    endfunction

    task automatic advance_meter(input t_pin_sample s);
        int       w;
        t_reading r;
        if (s.clr) begin
            for (w = 0; w < 2; w++) begin
                edge_cnt[w] = '0;
                tick_cnt[w] = '0;
                speed[w]    = '0;
            end
        end else begin
            edge_cnt[0] = count_edges(edge_cnt[0], s.w0_a, s.w0_b, last_pins[0], last_pins[1]);
            edge_cnt[1] = count_edges(edge_cnt[1], s.w1_a, s.w1_b, last_pins[2], last_pins[3]);
            if (s.tick) begin
                for (w = 0; w < 2; w++) begin
                    speed[w]    = wheel_speed(edge_cnt[w] - tick_cnt[w]);
                    tick_cnt[w] = edge_cnt[w];
                end
            end
        end
        last_pins = {s.w1_b, s.w1_a, s.w0_b, s.w0_a};
        r.count0 = edge_cnt[0];
        r.count1 = edge_cnt[1];
        r.speed0 = speed[0];
        r.speed1 = speed[1];
        readings_q.push_back(r);
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 50) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // Monitor: check results first, then predict the request taken at this edge
    always @(posedge i_clk) begin
        t_reading got, want;
        sample_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (!i_rst_n) begin
            circ_cfg  = CIRC_RST;
            ppr_cfg   = PPR_RST;
            spm_cfg   = SPM_RST;
            last_pins = '0;
            for (int w = 0; w < 2; w++) begin
                edge_cnt[w] = '0;
                tick_cnt[w] = '0;
                speed[w]    = '0;
            end
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_wheel0_count, o_wheel1_count, o_wheel0_speed, o_wheel1_speed};
                if (readings_q.size() == 0) begin
                    report_mismatch($sformatf("reading with no request pending: %h", got));
                end else begin
                    want = readings_q.pop_front();
                    for (int f = 0; f < 4; f++) begin
                        if (got[f*32 +: 32] !== want[f*32 +: 32]) begin
                            report_mismatch($sformatf("%s: got %0d, want %0d", field_name[f],
                                                      $signed(got[f*32 +: 32]),
                                                      $signed(want[f*32 +: 32])));
                        end
                    end
                    readings_checked++;
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_CIRC: circ_cfg = i_cfg_wr_data[CIRC_W-1:0];
                    REG_PPR:  ppr_cfg  = i_cfg_wr_data[PPR_W-1:0];
                    REG_SPM:  spm_cfg  = i_cfg_wr_data[SPM_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                advance_meter({i_wheel0_a_level, i_wheel0_b_level, i_wheel1_a_level,
                               i_wheel1_b_level, i_sample_tick, i_clear});
            end
        end
    end

    // Driver: bursts of requests separated by random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (sample_taken || !i_in_valid) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pin_samples_q.size() > 0) begin
                next_sample = pin_samples_q.pop_front();
                i_wheel0_a_level <= next_sample.w0_a;
                i_wheel0_b_level <= next_sample.w0_b;
                i_wheel1_a_level <= next_sample.w1_a;
                i_wheel1_b_level <= next_sample.w1_b;
                i_sample_tick    <= next_sample.tick;
                i_clear          <= next_sample.clr;
                i_in_valid       <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern that changes mode, plus a long hold-off now and then
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 96);
        end else begin
            mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (readings_checked >= next_hold_at) begin
            hold_left     = HOLD_CYCLES;
            next_hold_at += HOLD_SPACING;
            i_out_stall  <= 1'b1;
        end else begin
            case (stall_mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                default:     i_out_stall <= !i_out_stall;
            endcase
        end
    end

    task automatic queue_sample(input logic [1:0] w0, input logic [1:0] w1,
                                input logic tick, input logic clr);
        pin_samples_q.push_back({w0[1], w0[0], w1[1], w1[0], tick, clr});
        gen_w0 = w0;
        gen_w1 = w1;
        samples_sent++;
    endtask

    // Step one wheel's {a, b}: mostly a single-pin move in the wanted direction
    function automatic logic [1:0] walk_wheel(input logic [1:0] ab, input bit up);
        logic a_counts_up, b_counts_up;
        logic [1:0] any_flip;
        int roll;
        a_counts_up = ab[0];
        b_counts_up = !ab[1];
        any_flip    = $urandom_range(0, 1) ? 2'b10 : 2'b01;
        roll        = $urandom_range(0, 19);
        if (roll < 2) begin
            return ab;
        end
        if (roll == 2) begin
            return ~ab;
        end
        if (roll == 3 || (a_counts_up == up && b_counts_up == up)) begin
            return ab ^ any_flip;
        end
        if (a_counts_up == up) begin
            return ab ^ 2'b10;
        end
        if (b_counts_up == up) begin
            return ab ^ 2'b01;
        end
        return ab ^ any_flip;
    endfunction

    task automatic queue_motion(input int n, input int tick_lo, input int tick_hi,
                                input int run_max);
        int to_tick, run0, run1, k;
        bit up0, up1;
        to_tick = $urandom_range(tick_lo, tick_hi);
        run0 = 0;
        run1 = 0;
        up0  = 1'b1;
        up1  = 1'b0;
        for (k = 0; k < n; k++) begin
            if (run0 == 0) begin
                up0  = $urandom_range(0, 1);
                run0 = $urandom_range(1, run_max);
            end
            if (run1 == 0) begin
                up1  = $urandom_range(0, 1);
                run1 = $urandom_range(1, run_max);
            end
            run0--;
            run1--;
            to_tick--;
            queue_sample(walk_wheel(gen_w0, up0), walk_wheel(gen_w1, up1), to_tick == 0,
                         $urandom_range(0, 199) == 0);
            if (to_tick == 0) begin
                to_tick = $urandom_range(tick_lo, tick_hi);
            end
        end
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= idx;
        i_cfg_wr_data <= data;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic wait_drained();
        while (readings_checked < samples_sent) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default settings: single edges, both pins at once, ticks, clear
        queue_sample(2'b00, 2'b00, 1'b0, 1'b0);
        queue_sample(2'b01, 2'b10, 1'b0, 1'b0);
        queue_sample(2'b11, 2'b11, 1'b0, 1'b0);
        queue_sample(2'b11, 2'b11, 1'b1, 1'b0);
        queue_sample(2'b00, 2'b00, 1'b0, 1'b0);
        queue_sample(2'b11, 2'b01, 1'b1, 1'b0);
        queue_sample(2'b10, 2'b11, 1'b0, 1'b0);
        queue_sample(2'b10, 2'b11, 1'b1, 1'b0);
        queue_sample(2'b11, 2'b11, 1'b1, 1'b1);
        queue_sample(2'b11, 2'b11, 1'b0, 1'b0);
        queue_sample(2'b00, 2'b00, 1'b1, 1'b0);
        for (int k = 0; k < 3; k++) begin
            queue_sample(2'b01, 2'b10, 1'b0, 1'b0);
            queue_sample(2'b11, 2'b00, 1'b0, 1'b0);
        end
        queue_sample(2'b11, 2'b00, 1'b1, 1'b0);
        queue_sample(2'b00, 2'b11, 1'b0, 1'b1);
        queue_sample(2'b00, 2'b11, 1'b1, 1'b0);
        queue_motion(300, 1, 40, 60);
        wait_drained();

        // Largest scale: long runs drive the speed into saturation
        write_reg(REG_CIRC, 24'hFF_FFFF);
        write_reg(REG_PPR, 24'd1);
        write_reg(REG_SPM, 24'd1);
        queue_motion(250, 100, 220, 500);
        wait_drained();

        // Smallest scale: quotients truncate to zero
        write_reg(REG_CIRC, 24'd1);
        write_reg(REG_PPR, 24'd65535);
        write_reg(REG_SPM, 24'd1000);
        queue_motion(200, 1, 30, 60);
        wait_drained();

        // Zero divisor through pulses per revolution
        write_reg(REG_CIRC, 24'd204204);
        write_reg(REG_PPR, 24'd0);
        queue_motion(150, 1, 20, 60);
        wait_drained();

        // Upper data bits dropped; period ends up zero; spare index ignored
        write_reg(REG_PPR, 24'hFF_0001);
        write_reg(REG_SPM, 24'hFF_FC00);
        write_reg(REG_SPARE, 24'h00_0005);
        queue_motion(150, 1, 20, 60);
        wait_drained();

        write_reg(REG_CIRC, CFG_W'($urandom_range(1, 24'hFF_FFFF)));
        write_reg(REG_PPR, CFG_W'($urandom_range(1, 65535)));
        write_reg(REG_SPM, CFG_W'($urandom_range(1, 1000)));
        queue_motion(380, 1, 50, 100);
        wait_drained();

        // All-ones writes: largest divisor
        write_reg(REG_CIRC, 24'hFF_FFFF);
        write_reg(REG_PPR, 24'hFF_FFFF);
        write_reg(REG_SPM, 24'hFF_FFFF);
        queue_motion(200, 5, 60, 200);
        wait_drained();

        if (mismatches == 0 && readings_q.size() == 0) begin
            $display("PASS dual_quadrature_speed_meter");
        end else begin
            $display("FAIL dual_quadrature_speed_meter");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("FAIL dual_quadrature_speed_meter");
        $finish;
    end

endmodule
